// ===== rtl/bwt_pkg.sv =====
// Package for the breakpoint/watchpoint table: widths, codes, controller types
// and the type-code decode used by the datapath.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bwt_pkg;

  // fixed field widths
  localparam int ADDR_W   = 32;
  localparam int ACTION_W = 2;
  localparam int TYPE_W   = 4;
  localparam int STATUS_W = 2;
  localparam int TABLES   = 4;

  // default table depth
  localparam int SLOTS_PER_TABLE_DEF = 10;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CHECK  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_NONE   = 2'd3;

  // type codes
  localparam logic [TYPE_W-1:0] TYP_EXEC0  = 4'd0;
  localparam logic [TYPE_W-1:0] TYP_EXEC1  = 4'd1;
  localparam logic [TYPE_W-1:0] TYP_WRITE  = 4'd2;
  localparam logic [TYPE_W-1:0] TYP_READ   = 4'd3;
  localparam logic [TYPE_W-1:0] TYP_ACCESS = 4'd4;

  // table numbers
  localparam logic [1:0] TBL_EXEC   = 2'd0;
  localparam logic [1:0] TBL_WRITE  = 2'd1;
  localparam logic [1:0] TBL_READ   = 2'd2;
  localparam logic [1:0] TBL_ACCESS = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_TYPE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

  // configuration register indexes
  localparam logic REG_DEBUGGER_ATTACHED = 1'b0;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } bwt_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } bwt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic imm;
    logic is_add;
    logic free_here;
    logic out_busy;
  } bwt_stat_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] idx;
  } tsel_t;

  // type code to table number
  function automatic tsel_t table_of(input logic [TYPE_W-1:0] code);
    tsel_t r;
    r.valid = 1'b1;
    r.idx   = TBL_EXEC;
    case (code)
      TYP_EXEC0, TYP_EXEC1: r.idx = TBL_EXEC;
      TYP_WRITE:            r.idx = TBL_WRITE;
      TYP_READ:             r.idx = TBL_READ;
      TYP_ACCESS:           r.idx = TBL_ACCESS;
      default:              r.valid = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bwt_in_if.sv =====
// Request channel of the breakpoint/watchpoint table: valid/ready plus item fields.
// Depends on bwt_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bwt_in_if;
  import bwt_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [TYPE_W-1:0]   bp_type;
  logic [ADDR_W-1:0]   address;
  logic [ADDR_W-1:0]   length;

  modport source (output valid, output action, output bp_type, output address,
                  output length, input ready);
  modport sink (input valid, input action, input bp_type, input address,
                input length, output ready);
endinterface

`default_nettype wire

// ===== rtl/bwt_out_if.sv =====
// Response channel of the breakpoint/watchpoint table: valid/ready, status and hit.
// Depends on bwt_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bwt_out_if;
  import bwt_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                hit;

  modport source (output valid, output status, output hit, input ready);
  modport sink (input valid, input status, input hit, output ready);
endinterface

`default_nettype wire

// ===== rtl/bwt_ctrl.sv =====
// Controller of the breakpoint/watchpoint table: sequences the slot scan of one item.
// Depends on bwt_pkg; drives the datapath through bwt_cmd_t, reads bwt_stat_t.
`timescale 1ns / 1ps
`default_nettype none

module bwt_ctrl #(
  parameter int SLOTS_PER_TABLE = bwt_pkg::SLOTS_PER_TABLE_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  bwt_pkg::bwt_stat_t  stat,
  output bwt_pkg::bwt_cmd_t   cmd
);
  import bwt_pkg::*;

  localparam int SW = (SLOTS_PER_TABLE > 1) ? $clog2(SLOTS_PER_TABLE) : 1;
  localparam logic [SW-1:0] LAST = SW'(SLOTS_PER_TABLE - 1);

  bwt_state_t    state, state_next;
  logic [SW-1:0] slot, slot_next;
  logic          accept;

  assign accept = in_valid && in_ready;

  // state and slot counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slot  <= '0;
    end else begin
      state <= state_next;
      slot  <= slot_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    slot_next  = slot;
    case (state)
      S_IDLE: begin
        if (accept) begin
          slot_next  = '0;
          state_next = stat.imm ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.free_here) begin
          state_next = S_DONE;
        end else if (slot == LAST) begin
          state_next = stat.is_add ? S_DONE : S_DRAIN;
        end else begin
          slot_next = slot + 1'b1;
        end
      end
      S_DRAIN: state_next = S_DONE;
      S_DONE: begin
        if (!stat.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = accept;
      end
      S_SCAN:  cmd.step = 1'b1;
      S_DRAIN: cmd = '0;
      S_DONE:  cmd.emit = !stat.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/bwt_dpath.sv =====
// Datapath of the breakpoint/watchpoint table: item registers, slot memory,
// active bits, range compare and the result register. Depends on bwt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bwt_dpath #(
  parameter int SLOTS_PER_TABLE = bwt_pkg::SLOTS_PER_TABLE_DEF
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            attached,
  input  wire [bwt_pkg::ACTION_W-1:0]    in_action,
  input  wire [bwt_pkg::TYPE_W-1:0]      in_type,
  input  wire [bwt_pkg::ADDR_W-1:0]      in_address,
  input  wire [bwt_pkg::ADDR_W-1:0]      in_length,
  input  bwt_pkg::bwt_cmd_t              cmd,
  output bwt_pkg::bwt_stat_t             stat,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [bwt_pkg::STATUS_W-1:0]   out_status,
  output logic                           out_hit
);
  import bwt_pkg::*;

  localparam int TOTAL = TABLES * SLOTS_PER_TABLE;
  localparam int KW    = $clog2(TOTAL);
  localparam int WW    = 3 * ADDR_W;
  localparam logic [KW-1:0] BASE1 = KW'(SLOTS_PER_TABLE);
  localparam logic [KW-1:0] BASE2 = KW'(2 * SLOTS_PER_TABLE);
  localparam logic [KW-1:0] BASE3 = KW'(3 * SLOTS_PER_TABLE);

  // held item
  logic [ACTION_W-1:0] op_action;
  logic [ADDR_W-1:0]   op_addr;
  logic [ADDR_W-1:0]   op_len;
  logic [KW-1:0]       slot_k;
  logic [STATUS_W-1:0] res_status;
  logic                res_hit;

  // slot store: base, length, precomputed end
  logic [WW-1:0]       mem [TOTAL];
  logic [WW-1:0]       rd_word;
  logic [TOTAL-1:0]    active;
  logic                cmp_valid;
  logic [KW-1:0]       cmp_k;

  tsel_t               in_sel;
  logic [KW-1:0]       start_k;
  logic                in_imm;
  logic [STATUS_W-1:0] in_status;
  logic                op_add;
  logic                free_here;
  logic [ADDR_W-1:0]   rd_base, rd_len, rd_end;
  logic                rm_match, chk_hit;

  // decode of the arriving item
  always_comb begin
    in_sel = table_of(in_type);
    case (in_sel.idx)
      TBL_EXEC:   start_k = '0;
      TBL_WRITE:  start_k = BASE1;
      TBL_READ:   start_k = BASE2;
      TBL_ACCESS: start_k = BASE3;
      default:    start_k = '0;
    endcase
    in_imm    = 1'b0;
    in_status = ST_OK;
    if (in_action == ACT_NONE) begin
      in_imm = 1'b1;
    end else if (!in_sel.valid) begin
      in_imm    = 1'b1;
      in_status = ST_BAD_TYPE;
    end else if (in_action == ACT_CHECK && !attached) begin
      in_imm = 1'b1;
    end else if (in_action == ACT_ADD) begin
      in_status = ST_FULL;
    end
  end

  assign op_add    = (op_action == ACT_ADD);
  assign free_here = cmd.step && op_add && !active[slot_k];

  assign rd_base = rd_word[WW-1 -: ADDR_W];
  assign rd_len  = rd_word[2*ADDR_W-1 -: ADDR_W];
  assign rd_end  = rd_word[ADDR_W-1:0];

  // compare of the slot read in the previous cycle
  always_comb begin
    rm_match = cmp_valid && active[cmp_k] && (rd_base == op_addr) && (rd_len == op_len);
    chk_hit  = cmp_valid && active[cmp_k] && (op_addr >= rd_base) && (op_addr < rd_end);
  end

  assign stat.imm       = in_imm;
  assign stat.is_add    = op_add;
  assign stat.free_here = free_here;
  assign stat.out_busy  = out_valid && !out_ready;

  // item registers, scan pointer, result accumulation
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_action  <= in_action;
      op_addr    <= in_address;
      op_len     <= in_length;
      slot_k     <= start_k;
      res_status <= in_status;
      res_hit    <= 1'b0;
    end else begin
      if (cmd.step) slot_k <= slot_k + 1'b1;
      if (free_here) res_status <= ST_OK;
      if (chk_hit && op_action == ACT_CHECK) res_hit <= 1'b1;
    end
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (free_here) mem[slot_k] <= {op_addr, op_len, op_addr + op_len};
    rd_word <= mem[slot_k];
    cmp_k   <= slot_k;
  end

  // active bits and compare pipeline valid
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= '0;
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= cmd.step && !op_add;
      if (free_here) active[slot_k] <= 1'b1;
      if (rm_match && op_action == ACT_REMOVE) active[cmp_k] <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= res_status;
      out_hit    <= res_hit;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/breakpoint_watchpoint_table.sv =====
// Top level of the breakpoint/watchpoint table: configuration register port,
// controller and datapath. Depends on bwt_pkg, bwt_in_if, bwt_out_if,
// bwt_ctrl and bwt_dpath.
//
// Usage: requests arrive on in_item (action, bp_type, address, length) and
// each one yields exactly one response on out_item (status, hit). An item is
// taken when valid and ready are both high. Four tables (execute, write, read,
// access) of SLOTS_PER_TABLE slots each live in one slot memory.
// An item with an invalid type, an unused action, or a check with no debugger
// attached goes from idle straight to the done state. Add scans active bits
// one slot a cycle and stops at the first free slot or after the last slot.
// Remove and check read one slot a cycle from the single memory port through
// the whole table, then drain the registered read. One item at a time: the
// next item is taken only once the controller is back in idle.
// Reset clears the active bits and the debugger_attached register; slot
// contents stay undefined until written. A stalled receiver holds the
// response in the output register; the next item is taken meanwhile and
// finishes once the response is taken.
// debugger_attached sits at APB byte address 0; pready is always high.
`timescale 1ns / 1ps
`default_nettype none

module breakpoint_watchpoint_table #(
  parameter int SLOTS_PER_TABLE = bwt_pkg::SLOTS_PER_TABLE_DEF
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire [2:0]         paddr,
  input  wire [31:0]        pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  bwt_in_if.sink            in_item,
  bwt_out_if.source         out_item
);
  import bwt_pkg::*;

  logic      attached;
  logic      reg_wr;
  bwt_cmd_t  cmd;
  bwt_stat_t stat;

  // configuration register
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      attached <= 1'b0;
    end else if (reg_wr && paddr[2] == REG_DEBUGGER_ATTACHED) begin
      attached <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_DEBUGGER_ATTACHED) ? {31'd0, attached} : 32'd0;

  bwt_ctrl #(
    .SLOTS_PER_TABLE(SLOTS_PER_TABLE)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_item.valid),
    .in_ready (in_item.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bwt_dpath #(
    .SLOTS_PER_TABLE(SLOTS_PER_TABLE)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .attached   (attached),
    .in_action  (in_item.action),
    .in_type    (in_item.bp_type),
    .in_address (in_item.address),
    .in_length  (in_item.length),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_item.valid),
    .out_ready  (out_item.ready),
    .out_status (out_item.status),
    .out_hit    (out_item.hit)
  );

endmodule

`default_nettype wire

// ===== tb/tb_breakpoint_watchpoint_table.sv =====
// Self-checking testbench for breakpoint_watchpoint_table: directed and random
// add/remove/check requests with a scoreboard class that predicts every response.
// Depends on bwt_pkg, bwt_in_if, bwt_out_if and the breakpoint_watchpoint_table RTL.
`timescale 1ns / 1ps

module tb_breakpoint_watchpoint_table;
  import bwt_pkg::*;

  localparam int SLOTS = SLOTS_PER_TABLE_DEF;
  localparam logic [2:0] ATTACHED_ADDR = {REG_DEBUGGER_ATTACHED, 2'b00};

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                hit;
  } response_t;

  // range that was handed to an add, kept to aim removes and checks
  typedef struct {
    logic [TYPE_W-1:0] kind;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] span;
  } range_t;

  // shadow of the four slot tables and queue of predicted responses
  class bwt_scoreboard;
    bit                attached;
    bit                slot_used [TABLES*SLOTS];
    logic [ADDR_W-1:0] slot_base [TABLES*SLOTS];
    logic [ADDR_W-1:0] slot_span [TABLES*SLOTS];
    response_t         pending_responses[$];
    int                errors;
    int                requests;
    int                hits;
    int                fulls;
    int                bad_types;

    function void clear();
      attached = 1'b0;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      pending_responses.delete();
    endfunction

    function int table_index(logic [TYPE_W-1:0] kind);
      case (kind)
        TYP_EXEC0, TYP_EXEC1: return int'(TBL_EXEC);
        TYP_WRITE:            return int'(TBL_WRITE);
        TYP_READ:             return int'(TBL_READ);
        TYP_ACCESS:           return int'(TBL_ACCESS);
        default:              return -1;
      endcase
    endfunction

    // update the tables for an accepted item and queue its response
    function void note_request(logic [ACTION_W-1:0] act, logic [TYPE_W-1:0] kind,
                               logic [ADDR_W-1:0] addr, logic [ADDR_W-1:0] len);
      response_t         r;
      int                t;
      int                k;
      logic [ADDR_W-1:0] lim;
      r.status = ST_OK;
      r.hit    = 1'b0;
      t = table_index(kind);
      requests++;
      if (act != ACT_NONE && t < 0) begin
        r.status = ST_BAD_TYPE;
      end else if (act == ACT_ADD) begin
        r.status = ST_FULL;
        for (int s = 0; s < SLOTS; s++) begin
          k = t * SLOTS + s;
          if (!slot_used[k]) begin
            slot_used[k] = 1'b1;
            slot_base[k] = addr;
            slot_span[k] = len;
            r.status = ST_OK;
            break;
          end
        end
      end else if (act == ACT_REMOVE) begin
        for (int s = 0; s < SLOTS; s++) begin
          k = t * SLOTS + s;
          if (slot_used[k] && slot_base[k] == addr && slot_span[k] == len)
            slot_used[k] = 1'b0;
        end
      end else if (act == ACT_CHECK && attached) begin
        for (int s = 0; s < SLOTS; s++) begin
          k = t * SLOTS + s;
          lim = slot_base[k] + slot_span[k];
          if (slot_used[k] && addr >= slot_base[k] && addr < lim) begin
            r.hit = 1'b1;
            break;
          end
        end
      end
      if (r.hit) hits++;
      if (r.status == ST_FULL) fulls++;
      if (r.status == ST_BAD_TYPE) bad_types++;
      pending_responses.push_back(r);
    endfunction

    // compare a taken response with the oldest prediction
    function void check_response(logic [STATUS_W-1:0] status, logic hit);
      response_t want;
      if (pending_responses.size() == 0) begin
        $error("response with nothing expected: status %0d hit %0d", status, hit);
        errors++;
        return;
      end
      want = pending_responses.pop_front();
      if (status !== want.status) begin
        $error("status mismatch: expected %0d, got %0d", want.status, status);
        errors++;
      end
      if (hit !== want.hit) begin
        $error("hit mismatch: expected %0d, got %0d", want.hit, hit);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bwt_in_if  in_bus ();
  bwt_out_if out_bus ();

  bwt_scoreboard sb;
  range_t        ranges[$];
  int            sent;
  bit            send_idle;

  breakpoint_watchpoint_table #(.SLOTS_PER_TABLE(SLOTS)) uut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_item  (in_bus),
    .out_item (out_bus)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // overall time limit
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // both channels are sampled at the edge where an item moves
  always @(posedge clk) begin
    if (!rst) begin
      if (out_bus.valid && out_bus.ready)
        sb.check_response(out_bus.status, out_bus.hit);
      if (in_bus.valid && in_bus.ready)
        sb.note_request(in_bus.action, in_bus.bp_type, in_bus.address, in_bus.length);
    end
  end

  // receiver: random stalls, quiet stretches and two long hold-offs
  initial begin : receiver
    int  taken;
    int  hold;
    bit  recv_idle;
    taken = 0;
    recv_idle = 1'b1;
    out_bus.ready = 1'b0;
    forever begin
      if (taken % 25 == 0) recv_idle = $urandom_range(0, 2) != 0;
      hold = recv_idle ? $urandom_range(0, 9) : 0;
      if (taken == 90 || taken == 330) hold = 300;
      if (hold > 0) begin
        out_bus.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!(out_bus.valid && !rst));
      taken++;
    end
  end

  // offer one item after a random gap and wait until it is taken
  task automatic issue_request(logic [ACTION_W-1:0] act, logic [TYPE_W-1:0] kind,
                               logic [ADDR_W-1:0] addr, logic [ADDR_W-1:0] len);
    int gap;
    if (sent % 25 == 0) send_idle = $urandom_range(0, 2) != 0;
    gap = send_idle ? $urandom_range(0, 9) : 0;
    sent++;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.action  <= act;
    in_bus.bp_type <= kind;
    in_bus.address <= addr;
    in_bus.length  <= len;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // stop offering and let every response come back
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_responses.size() != 0) @(posedge clk);
    repeat (SLOTS + 4) @(posedge clk);
  endtask

  // apb write of debugger_attached, only while the block is idle
  task automatic set_attached(logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ATTACHED_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.attached = value[0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [TYPE_W-1:0] same_kind(logic [TYPE_W-1:0] kind);
    if (kind == TYP_EXEC0 || kind == TYP_EXEC1)
      return $urandom_range(0, 1) ? TYP_EXEC1 : TYP_EXEC0;
    return kind;
  endfunction

  function automatic bit same_table(logic [TYPE_W-1:0] a, logic [TYPE_W-1:0] b);
    return (a <= TYP_EXEC1 && b <= TYP_EXEC1) || a == b;
  endfunction

  // random item; removes and checks are mostly aimed at ranges that were added earlier
  task automatic random_request();
    int                roll;
    int                pick;
    logic [ACTION_W-1:0] act;
    logic [TYPE_W-1:0] kind;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] len;
    range_t            r;
    roll = $urandom_range(0, 99);
    kind = ($urandom_range(0, 19) == 0) ? TYPE_W'($urandom_range(5, 15))
                                        : TYPE_W'($urandom_range(0, 4));
    addr = $urandom;
    len  = $urandom;
    if (roll < 40) begin
      act = ACT_ADD;
      case ($urandom_range(0, 9))
        0: len = '0;
        1: ;
        2: begin
          addr = 32'hFFFF_FF00 | ADDR_W'($urandom_range(0, 255));
          len  = ADDR_W'($urandom_range(1, 512));
        end
        default: len = ADDR_W'($urandom_range(1, 256));
      endcase
      if (kind <= TYP_ACCESS) begin
        ranges.push_back('{kind, addr, len});
        if (ranges.size() > 48) ranges.delete(0);
      end
    end else if (roll < 60) begin
      act = ACT_REMOVE;
      if (ranges.size() > 0 && $urandom_range(0, 4) != 0) begin
        pick = $urandom_range(0, ranges.size() - 1);
        r    = ranges[pick];
        kind = same_kind(r.kind);
        addr = r.base;
        len  = r.span;
        for (int i = ranges.size() - 1; i >= 0; i--)
          if (same_table(ranges[i].kind, kind) && ranges[i].base == addr &&
              ranges[i].span == len)
            ranges.delete(i);
      end
    end else if (roll < 95) begin
      act = ACT_CHECK;
      if (ranges.size() > 0 && $urandom_range(0, 6) != 0) begin
        pick = $urandom_range(0, ranges.size() - 1);
        r    = ranges[pick];
        kind = same_kind(r.kind);
        case ($urandom_range(0, 4))
          0: addr = r.base;
          1: addr = r.base + r.span - 1;
          2: addr = r.base + r.span;
          3: addr = r.base - 1;
          default: addr = r.base + ((r.span == 0) ? '0 : ($urandom % r.span));
        endcase
      end
    end else begin
      act = ACT_NONE;
    end
    issue_request(act, kind, addr, len);
  endtask

  // main sequence
  initial begin
    sb = new();
    sb.clear();
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_bus.valid = 1'b0;
    in_bus.action = ACT_ADD;
    in_bus.bp_type = TYP_EXEC0;
    in_bus.address = '0;
    in_bus.length = '0;
    sent = 0;
    send_idle = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, wrapping and empty ranges, invalid codes, full table
    set_attached(32'h1);
    issue_request(ACT_ADD, TYP_EXEC0, 32'h0000_1000, 32'h10);
    issue_request(ACT_ADD, TYP_EXEC1, 32'hFFFF_FFF0, 32'h20);
    issue_request(ACT_ADD, TYP_WRITE, 32'h0, 32'h0);
    issue_request(ACT_ADD, TYP_READ, 32'hFFFF_FFFF, 32'h1);
    issue_request(ACT_ADD, TYP_ACCESS, 32'h0, 32'hFFFF_FFFF);
    issue_request(ACT_CHECK, TYP_EXEC0, 32'h0000_1000, 32'h0);
    issue_request(ACT_CHECK, TYP_EXEC1, 32'h0000_100F, 32'hFFFF_FFFF);
    issue_request(ACT_CHECK, TYP_EXEC0, 32'h0000_1010, 32'h0);
    issue_request(ACT_CHECK, TYP_EXEC0, 32'hFFFF_FFF8, 32'h0);
    issue_request(ACT_CHECK, TYP_WRITE, 32'h0, 32'h0);
    issue_request(ACT_CHECK, TYP_READ, 32'hFFFF_FFFF, 32'h0);
    issue_request(ACT_CHECK, TYP_ACCESS, 32'hFFFF_FFFE, 32'h0);
    issue_request(ACT_ADD, 4'hF, 32'h0000_2000, 32'h10);
    issue_request(ACT_CHECK, TYP_ACCESS + 4'd1, 32'h0, 32'h0);
    issue_request(ACT_REMOVE, 4'h9, 32'h0000_1000, 32'h10);
    issue_request(ACT_NONE, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_request(ACT_REMOVE, TYP_EXEC0, 32'h0000_1000, 32'h11);
    issue_request(ACT_REMOVE, TYP_EXEC1, 32'h0000_1000, 32'h10);
    issue_request(ACT_CHECK, TYP_EXEC0, 32'h0000_1000, 32'h0);
    // write table holds one slot already: nine more fill it, the tenth is refused
    for (int i = 1; i <= SLOTS; i++)
      issue_request(ACT_ADD, TYP_WRITE, ADDR_W'(i) << 8, 32'h80);
    wait_drained();

    // random phases with the debugger detached and attached
    set_attached($urandom & 32'hFFFF_FFFE);
    repeat (100) random_request();
    wait_drained();
    set_attached($urandom | 32'h1);
    repeat (200) random_request();
    wait_drained();
    set_attached(32'hFFFF_FFFE);
    repeat (50) random_request();
    wait_drained();
    set_attached(32'hFFFF_FFFF);
    repeat (100) random_request();
    wait_drained();

    $display("covered %0d requests: %0d hits, %0d adds on a full table, %0d invalid types",
             sb.requests, sb.hits, sb.fulls, sb.bad_types);
    $display("debugger detached and attached, two long response stalls");
    if (sb.errors == 0 && sb.pending_responses.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
